>>> hw/rtl/bitmap_hline_fill_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the horizontal line fill core
// Shared clocked assertion forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BITMAP_HLINE_FILL_CORE_DEFINES_SVH
`define BITMAP_HLINE_FILL_CORE_DEFINES_SVH

// property holds at every edge outside reset
`define BHF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent at one edge implies consequent at the next
`define BHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bhf_pkg.sv
// ----------------------------------------------------------------------------
// bhf_pkg
// Constants and types of the horizontal line fill core.
// ----------------------------------------------------------------------------
package bhf_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int FRAME_DEPTH = (MAX_WIDTH / 8) * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int COL_W       = 8;
  localparam int ROW_W       = 8;
  localparam int CFG_W       = 9;
  localparam int WB_W        = CFG_W - 3;
  localparam int BCOL_W      = $clog2(MAX_WIDTH / 8);
  localparam int IDX_W       = 2;

  localparam logic [7:0] ALL_ONES = 8'hFF;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic KIND_DRAW  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] width_pixels;
    logic [CFG_W-1:0] height_rows;
  } cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

endpackage

>>> hw/rtl/bhf_channels.sv
// ----------------------------------------------------------------------------
// bhf channels
// Valid/ready channel interfaces: input items, result items, config writes.
// ----------------------------------------------------------------------------
interface bhf_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [bhf_pkg::COL_W-1:0] x_start;
  logic [bhf_pkg::COL_W-1:0] x_end;
  logic [bhf_pkg::ROW_W-1:0] row;

  modport source (output valid, kind, x_start, x_end, row, input ready);
  modport sink   (input valid, kind, x_start, x_end, row, output ready);
endinterface

interface bhf_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic pixel_lit;

  modport source (output valid, accepted, pixel_lit, input ready);
  modport sink   (input valid, accepted, pixel_lit, output ready);
endinterface

interface bhf_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [bhf_pkg::IDX_W-1:0] idx;
  logic [bhf_pkg::CFG_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

>>> hw/rtl/bitmap_hline_fill_core.sv
// ----------------------------------------------------------------------------
// bitmap_hline_fill_core
// Monochrome 1 bpp framebuffer with horizontal line fill and pixel query.
// ----------------------------------------------------------------------------
// Channels: in_ch takes items (kind 0 draws x_start..x_end-1 on row, kind 1
// queries pixel x_start of row); out_ch returns one result per item with
// accepted and pixel_lit; cfg_ch writes width_pixels (index 0) and
// height_rows (index 1), always ready, other indexes are dropped.
// Pixels sit eight to a byte, MSB leftmost, rows width_pixels/8 bytes apart.
// Sequence: an item is accepted, then range checks and the row base address
// are done, then each touched byte gets a read-modify-write (through the
// single-port-per-direction byte memory, write-back in the cycle after the
// read), then a drain state and a response state; a query reads its byte and
// waits for it before responding, a rejected item goes straight to response.
// One item is in flight at a time; in_ch.ready is high only while idle.
// Reset: width 64, height 32, then a clearing pass zeroes all 8192 bytes of the
// frame memory with in_ch.ready low.
// Stall: the result waits in the output register while out_ch.ready is low;
// a following item may be accepted and processed, holding in its response
// cycle until the register frees.
// ----------------------------------------------------------------------------
module bitmap_hline_fill_core (
  input  logic      clk,
  input  logic      rst_n,
  bhf_in_if.sink    in_ch,
  bhf_out_if.source out_ch,
  bhf_cfg_if.sink   cfg_ch
);

  bhf_pkg::cfg_t     cfg;
  bhf_pkg::mem_req_t mem_req;
  logic [7:0]        rdata;

  bhf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bhf_frame_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  bhf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

endmodule

>>> hw/rtl/bhf_frame_ram.sv
// ----------------------------------------------------------------------------
// bhf_frame_ram
// Byte-wide frame memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bhf_frame_ram (
  input  logic              clk,
  input  bhf_pkg::mem_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [bhf_pkg::FRAME_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bhf_cfg_regs.sv
// ----------------------------------------------------------------------------
// bhf_cfg_regs
// Width and height registers behind the config write channel.
// ----------------------------------------------------------------------------
module bhf_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  bhf_cfg_if.sink       cfg_ch,
  output bhf_pkg::cfg_t cfg
);

  logic [bhf_pkg::CFG_W-1:0] width_r;
  logic [bhf_pkg::CFG_W-1:0] height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd64;
      height_r <= 9'd32;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        bhf_pkg::REG_WIDTH:  width_r  <= cfg_ch.data;
        bhf_pkg::REG_HEIGHT: height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg.width_pixels = width_r;
  assign cfg.height_rows  = height_r;

endmodule

>>> hw/rtl/bhf_ctrl.sv
// ----------------------------------------------------------------------------
// bhf_ctrl
// Item sequencer: range checks, per-byte read-modify-write, pixel query,
// clearing pass after reset and the result register.
// ----------------------------------------------------------------------------
`include "bitmap_hline_fill_core_defines.svh"

module bhf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  bhf_in_if.sink            in_ch,
  bhf_out_if.source         out_ch,
  input  bhf_pkg::cfg_t     cfg,
  output bhf_pkg::mem_req_t mem_req,
  input  logic [7:0]        rdata
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_QRD   = 3'd5;
  localparam logic [2:0] ST_QWAIT = 3'd6;
  localparam logic [2:0] ST_RESP  = 3'd7;

  localparam int AW = bhf_pkg::ADDR_W;
  localparam int BW = bhf_pkg::BCOL_W;

  logic [2:0]                 state_r, state_nxt;
  logic [AW-1:0]              clr_addr_r, clr_addr_nxt;
  logic                       kind_r;
  logic [bhf_pkg::COL_W-1:0]  xs_r, xe_r;
  logic [bhf_pkg::ROW_W-1:0]  row_r;
  logic [AW-1:0]              base_r, base_nxt;
  logic [BW-1:0]              b_r, b_nxt;
  logic [BW-1:0]              first_r, first_nxt;
  logic [BW-1:0]              last_r, last_nxt;
  logic [7:0]                 fmask_r, fmask_nxt;
  logic [7:0]                 lmask_r, lmask_nxt;
  logic                       p_vld_r, p_vld_nxt;
  logic [AW-1:0]              p_addr_r, p_addr_nxt;
  logic [7:0]                 p_mask_r, p_mask_nxt;
  logic                       res_acc_r, res_acc_nxt;
  logic                       res_lit_r, res_lit_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_acc_r, out_lit_r;
  logic                       out_load;

  logic                       in_fire;
  logic                       usable, draw_ok, query_ok;
  logic [bhf_pkg::COL_W-1:0]  xe_m1;
  logic [bhf_pkg::ROW_W+bhf_pkg::WB_W-1:0] base_full;
  logic [7:0]                 run_mask;
  logic [AW-1:0]              run_addr;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign usable = (cfg.width_pixels[2:0] == 3'd0)
               && (cfg.width_pixels <= bhf_pkg::CFG_W'(bhf_pkg::MAX_WIDTH))
               && (cfg.height_rows <= bhf_pkg::CFG_W'(bhf_pkg::MAX_HEIGHT));
  assign draw_ok = usable && (xe_r > xs_r)
                && ({1'b0, xs_r} < cfg.width_pixels)
                && ({1'b0, xe_r} < cfg.width_pixels)
                && ({1'b0, row_r} < cfg.height_rows);
  assign query_ok = usable && ({1'b0, xs_r} < cfg.width_pixels)
                 && ({1'b0, row_r} < cfg.height_rows);

  assign xe_m1     = xe_r - 8'd1;
  assign base_full = (bhf_pkg::ROW_W+bhf_pkg::WB_W)'(row_r)
                   * (bhf_pkg::ROW_W+bhf_pkg::WB_W)'(cfg.width_pixels[bhf_pkg::CFG_W-1:3]);

  always_comb begin
    run_mask = bhf_pkg::ALL_ONES;
    if (b_r == first_r) begin
      run_mask = run_mask & fmask_r;
    end
    if (b_r == last_r) begin
      run_mask = run_mask & lmask_r;
    end
  end

  assign run_addr = base_r + AW'(b_r);
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    base_nxt     = base_r;
    b_nxt        = b_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    fmask_nxt    = fmask_r;
    lmask_nxt    = lmask_r;
    p_vld_nxt    = 1'b0;
    p_addr_nxt   = p_addr_r;
    p_mask_nxt   = p_mask_r;
    res_acc_nxt  = res_acc_r;
    res_lit_nxt  = res_lit_r;
    mem_req      = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr_r;
        mem_req.wr_data = 8'd0;
        clr_addr_nxt    = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(bhf_pkg::FRAME_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        base_nxt    = base_full[AW-1:0];
        res_acc_nxt = 1'b0;
        res_lit_nxt = 1'b0;
        state_nxt   = ST_RESP;
        if (kind_r == bhf_pkg::KIND_DRAW) begin
          if (draw_ok) begin
            b_nxt     = xs_r[7:3];
            first_nxt = xs_r[7:3];
            last_nxt  = xe_m1[7:3];
            fmask_nxt = bhf_pkg::ALL_ONES >> xs_r[2:0];
            lmask_nxt = bhf_pkg::ALL_ONES << (3'd7 - xe_m1[2:0]);
            state_nxt = ST_RUN;
          end
        end else if (query_ok) begin
          state_nxt = ST_QRD;
        end
      end
      ST_RUN: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = run_addr;
        p_vld_nxt       = 1'b1;
        p_addr_nxt      = run_addr;
        p_mask_nxt      = run_mask;
        b_nxt           = b_r + 1'b1;
        if (b_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        res_acc_nxt = 1'b1;
        res_lit_nxt = 1'b0;
        state_nxt   = ST_RESP;
      end
      ST_QRD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = base_r + AW'(xs_r[7:3]);
        state_nxt       = ST_QWAIT;
      end
      ST_QWAIT: begin
        res_acc_nxt = 1'b1;
        res_lit_nxt = rdata[3'd7 - xs_r[2:0]];
        state_nxt   = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // write-back half of the read-modify-write
    if (p_vld_r) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = p_addr_r;
      mem_req.wr_data = rdata | p_mask_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_ch.kind;
      xs_r   <= in_ch.x_start;
      xe_r   <= in_ch.x_end;
      row_r  <= in_ch.row;
    end
    if (out_load) begin
      out_acc_r <= res_acc_r;
      out_lit_r <= res_lit_r;
    end
    base_r    <= base_nxt;
    b_r       <= b_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    fmask_r   <= fmask_nxt;
    lmask_r   <= lmask_nxt;
    p_addr_r  <= p_addr_nxt;
    p_mask_r  <= p_mask_nxt;
    res_acc_r <= res_acc_nxt;
    res_lit_r <= res_lit_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.accepted  = out_acc_r;
  assign out_ch.pixel_lit = out_lit_r;

  `BHF_ASSERT_RST(a_no_rw_collide, !(mem_req.wr_en && mem_req.rd_en && (mem_req.wr_addr == mem_req.rd_addr)), "read and write hit the same byte")
  `BHF_ASSERT_NEXT(a_run_writes_back, state_r == ST_RUN, p_vld_r, "line byte read without write-back")
  `BHF_ASSERT_RST(a_idle_no_write, (state_r == ST_IDLE) |-> !mem_req.wr_en, "frame write while idle")
  `BHF_ASSERT_RST(a_lit_needs_acc, (out_valid_r && out_lit_r) |-> out_acc_r, "lit pixel on rejected item")
  `BHF_ASSERT_RST(a_result_from_resp, $rose(out_valid_r) |-> $past(state_r == ST_RESP), "result raised outside response state")

endmodule
